@@ rtl/mdt_pkg.sv @@
package mdt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int HW_SLOTS    = 16;
  localparam int USABLE      = (TIMER_SLOTS < HW_SLOTS) ? TIMER_SLOTS : HW_SLOTS;
  localparam int SLOT_W      = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam int CNT_W       = $clog2(USABLE + 1);
  localparam int TIME_W      = 32;
  localparam int ENTRY_W     = 2 * TIME_W;

  typedef enum logic [1:0] {
    OP_TICK           = 2'd0,
    OP_START_PERIODIC = 2'd1,
    OP_START_ONESHOT  = 2'd2,
    OP_STOP           = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

endpackage

@@ rtl/mdt_ram.sv @@
module mdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/multi_slot_deadline_timer_unit.sv @@
// Channel   Direction  Handshake          Word
// command   in         start / busy       op, slot, duration
// result    out        strobe, one cycle  kind, slot_out, accepted, now, last
//
// Start and stop commands never raise busy, and a start reply appears on the cycle after
// acceptance. A tick holds busy from its accepting edge until the scan ends: the scan
// reads one slot per cycle from the slot RAM, whose read port sets the pace. The last
// expiry word of a tick comes out in the first cycle after busy falls, and a new tick
// is accepted only once busy is low.
// Reset clears the time count and the active flags at once; there is no clearing pass.
// The receiver cannot stall, and results leave on consecutive or spaced cycles.
module multi_slot_deadline_timer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [3:0]  slot,
  input  logic [31:0] duration,
  output logic        strobe,
  output logic        kind,
  output logic [3:0]  slot_out,
  output logic        accepted,
  output logic [31:0] now,
  output logic        last
);

  import mdt_pkg::*;

  state_t state, state_next;

  logic [TIME_W-1:0]  time_count;
  logic [USABLE-1:0]  active;
  logic [CNT_W-1:0]   idx;
  logic               ev_valid;
  logic [SLOT_W-1:0]  ev_slot;
  logic               pend_valid;
  logic [SLOT_W-1:0]  pend_slot;

  logic               accept;
  op_t                cmd;
  logic               in_range;
  logic [SLOT_W-1:0]  cmd_slot;
  logic               start_ok;
  logic               issue;
  logic               scan_done;
  logic [TIME_W-1:0]  ev_deadline;
  logic [TIME_W-1:0]  ev_period;
  logic [TIME_W-1:0]  ev_diff;
  logic               ev_expired;

  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [SLOT_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  mdt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(USABLE)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign accept   = start && !busy;
  assign cmd      = op_t'(op);
  assign in_range = ({1'b0, slot} < 5'(USABLE));
  assign cmd_slot = slot[SLOT_W-1:0];
  assign start_ok = accept && (cmd == OP_START_PERIODIC || cmd == OP_START_ONESHOT)
                    && in_range && (duration != '0);

  assign ev_deadline = rd_data[ENTRY_W-1:TIME_W];
  assign ev_period   = rd_data[TIME_W-1:0];
  assign ev_diff     = ev_deadline - time_count;
  assign ev_expired  = ev_valid && active[ev_slot] && (ev_diff == '0 || ev_diff[TIME_W-1]);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == OP_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state == ST_SCAN);
    issue     = (state == ST_SCAN) && (idx < CNT_W'(USABLE));
    scan_done = (state == ST_SCAN) && !issue && !ev_valid;
    rd_addr   = idx[SLOT_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = cmd_slot;
    wr_data   = {time_count + duration, (cmd == OP_START_PERIODIC) ? duration : '0};
    if (start_ok) begin
      wr_en = 1'b1;
    end else if (ev_expired && ev_period != '0) begin
      wr_en   = 1'b1;
      wr_addr = ev_slot;
      wr_data = {ev_deadline + ev_period, ev_period};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      time_count <= '0;
      active     <= '0;
      idx        <= '0;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;

      if (accept) begin
        case (cmd)
          OP_TICK: begin
            time_count <= time_count + TIME_W'(1);
            idx        <= '0;
            ev_valid   <= 1'b0;
            pend_valid <= 1'b0;
          end
          OP_STOP: begin
            if (in_range) begin
              active[cmd_slot] <= 1'b0;
            end
          end
          default: begin
            strobe   <= 1'b1;
            kind     <= KIND_REPLY;
            slot_out <= slot;
            accepted <= start_ok;
            now      <= time_count;
            last     <= 1'b1;
            if (in_range) begin
              active[cmd_slot] <= (duration != '0);
            end
          end
        endcase
      end

      if (state == ST_SCAN) begin
        ev_valid <= issue;
        ev_slot  <= idx[SLOT_W-1:0];
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end

        // An expiry is held back until the next one so the final word can carry last.
        if (ev_expired) begin
          if (ev_period == '0) begin
            active[ev_slot] <= 1'b0;
          end
          if (pend_valid) begin
            strobe   <= 1'b1;
            kind     <= KIND_EXPIRY;
            slot_out <= 4'(pend_slot);
            accepted <= 1'b0;
            now      <= time_count;
            last     <= 1'b0;
          end
          pend_valid <= 1'b1;
          pend_slot  <= ev_slot;
        end

        if (scan_done && pend_valid) begin
          strobe     <= 1'b1;
          kind       <= KIND_EXPIRY;
          slot_out   <= 4'(pend_slot);
          accepted   <= 1'b0;
          now        <= time_count;
          last       <= 1'b1;
          pend_valid <= 1'b0;
        end
      end
    end
  end

endmodule

@@ sim/tb_multi_slot_deadline_timer_unit.sv @@
`timescale 1ns / 1ps

module tb_multi_slot_deadline_timer_unit;
  import mdt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_CMDS = 420;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    op_t         op;
    logic [3:0]  slot;
    logic [31:0] duration;
    bit          drain;
  } command_t;

  typedef struct {
    logic        kind;
    logic [3:0]  slot_out;
    logic        accepted;
    logic [31:0] now;
    logic        last;
  } timer_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = '0;
  logic [3:0]  slot = '0;
  logic [31:0] duration = '0;
  logic        strobe;
  logic        kind;
  logic [3:0]  slot_out;
  logic        accepted;
  logic [31:0] now;
  logic        last;

  command_t    command_q[$];
  timer_word_t due_q[$];
  command_t    issued;

  logic [31:0] clock_count = '0;
  logic [31:0] deadline_m[HW_SLOTS];
  logic [31:0] period_m[HW_SLOTS];
  bit          armed_m[HW_SLOTS];

  int idle_left;
  int calm_left;
  int fail_count;
  int shown;
  int cycles;
  int sent;
  int ticks;
  int words;

  multi_slot_deadline_timer_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .slot(slot),
    .duration(duration),
    .strobe(strobe),
    .kind(kind),
    .slot_out(slot_out),
    .accepted(accepted),
    .now(now),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic advance_timers(input command_t c);
    timer_word_t batch[$];
    timer_word_t w;
    logic [31:0] diff;
    logic        acc;
    case (c.op)
      OP_TICK: begin
        clock_count = clock_count + 32'd1;
        for (int i = 0; i < USABLE; i++) begin
          if (armed_m[i]) begin
            diff = deadline_m[i] - clock_count;
            if (diff == 32'd0 || diff[31]) begin
              w = '{KIND_EXPIRY, 4'(i), 1'b0, clock_count, 1'b0};
              batch.push_back(w);
              if (period_m[i] != 32'd0) begin
                deadline_m[i] = deadline_m[i] + period_m[i];
              end else begin
                armed_m[i] = 1'b0;
              end
            end
          end
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) due_q.push_back(batch[k]);
      end
      OP_STOP: begin
        if (int'(c.slot) < USABLE) armed_m[c.slot] = 1'b0;
      end
      default: begin
        acc = 1'b0;
        if (int'(c.slot) < USABLE) begin
          if (c.duration == 32'd0) begin
            armed_m[c.slot] = 1'b0;
          end else begin
            period_m[c.slot] = (c.op == OP_START_PERIODIC) ? c.duration : 32'd0;
            deadline_m[c.slot] = clock_count + c.duration;
            armed_m[c.slot] = 1'b1;
            acc = 1'b1;
          end
        end
        w = '{KIND_REPLY, c.slot, acc, clock_count, 1'b1};
        due_q.push_back(w);
      end
    endcase
  endtask

  always @(posedge clk) begin
    bit took;
    int r;
    took = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        advance_timers(issued);
        sent++;
        if (issued.op == OP_TICK) ticks++;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
          calm_left--;
          idle_left = 0;
        end else if (r < 3) begin
          calm_left = $urandom_range(20, 40);
          idle_left = 0;
        end else if (r < 55) begin
          idle_left = 0;
        end else if (r < 88) begin
          idle_left = $urandom_range(1, 4);
        end else begin
          idle_left = $urandom_range(8, 40);
        end
      end
      if (!start || took) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (command_q.size() != 0 &&
                     !(command_q[0].drain && due_q.size() != 0)) begin
          issued = command_q.pop_front();
          start <= 1'b1;
          op <= issued.op;
          slot <= issued.slot;
          duration <= issued.duration;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    timer_word_t want;
    if (!rst && strobe) begin
      words++;
      if (due_q.size() == 0) begin
        fail_count++;
        if (shown < 10) begin
          shown++;
          $display("Unexpected result word: kind %0d slot %0d accepted %0d now %0d last %0d",
                   kind, slot_out, accepted, now, last);
        end
      end else begin
        want = due_q.pop_front();
        if (kind !== want.kind || slot_out !== want.slot_out ||
            accepted !== want.accepted || now !== want.now || last !== want.last) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("Mismatch: expected kind %0d slot %0d accepted %0d now %0d last %0d",
                     want.kind, want.slot_out, want.accepted, want.now, want.last);
            $display("          actual   kind %0d slot %0d accepted %0d now %0d last %0d",
                     kind, slot_out, accepted, now, last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result words still due",
               cycles, due_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    command_t c;
    int r;
    c.drain = 1'b0;
    for (int i = 0; i < 16; i++) begin
      c.slot = 4'(i);
      c.duration = (i == 1 || i == 14) ? 32'hFFFF_FFFF : 32'd1;
      if (i == 1 || i == 2) begin
        c.op = OP_START_ONESHOT;
      end else begin
        c.op = OP_START_PERIODIC;
      end
      command_q.push_back(c);
    end
    command_q.push_back('{OP_TICK, 4'd0, 32'd0, 1'b0});
    command_q.push_back('{OP_TICK, 4'd15, 32'hFFFF_FFFF, 1'b0});
    command_q.push_back('{OP_STOP, 4'd3, 32'd0, 1'b0});
    command_q.push_back('{OP_START_ONESHOT, 4'd4, 32'd0, 1'b0});
    command_q.push_back('{OP_START_ONESHOT, 4'd0, 32'd2, 1'b0});
    command_q.push_back('{OP_START_ONESHOT, 4'd15, 32'h8000_0000, 1'b0});
    command_q.push_back('{OP_START_PERIODIC, 4'd13, 32'h8000_0001, 1'b0});
    command_q.push_back('{OP_TICK, 4'd0, 32'd0, 1'b0});
    command_q.push_back('{OP_TICK, 4'd0, 32'd0, 1'b0});
    command_q.push_back('{OP_TICK, 4'd0, 32'd0, 1'b0});

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      c.slot = 4'($urandom_range(0, 15));
      c.duration = $urandom;
      c.drain = (n % 100 == 0);
      if (r < 45) begin
        c.op = OP_TICK;
      end else if (r < 65) begin
        c.op = OP_START_PERIODIC;
      end else if (r < 85) begin
        c.op = OP_START_ONESHOT;
      end else begin
        c.op = OP_STOP;
      end
      if (c.op == OP_START_PERIODIC || c.op == OP_START_ONESHOT) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          c.duration = 32'd0;
        end else if (r < 70) begin
          c.duration = $urandom_range(1, 24);
        end else if (r < 80) begin
          c.duration = $urandom_range(25, 400);
        end else if (r < 86) begin
          c.duration = 32'h7FFF_FFFF + $urandom_range(0, 2);
        end else if (r < 92) begin
          c.duration = 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
      end
      command_q.push_back(c);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (command_q.size() != 0 || start || busy || due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands, %0d of them ticks, and checked %0d result words.",
             sent, ticks, words);
    $display("Covered full-slot expiry, extreme and zero durations, restarts and stops.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mdt_pkg.sv
rtl/mdt_ram.sv
rtl/multi_slot_deadline_timer_unit.sv
sim/tb_multi_slot_deadline_timer_unit.sv
